// ===== rtl/sgr_pkg.sv =====
`default_nettype none

package sgr_pkg;

    localparam int PixW    = 8;
    localparam int GradW   = 13;
    localparam int OutColW = 11;
    localparam int RowW    = 12;
    localparam int CfgW    = 12;
    localparam int SmoothW = 12;

    localparam logic       REG_IMAGE_WIDTH  = 1'b0;
    localparam logic       REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CfgW-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CfgW-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [PixW-1:0]  pix_t;
    typedef logic signed [GradW-1:0] grad_t;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic has_result;
        logic last;
    } sgr_ctl_t;

    // 3*(a+b) + 10*m, max 4080
    function automatic logic [SmoothW-1:0] smooth3(input pix_t a, input pix_t m, input pix_t b);
        logic [PixW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            smooth3 = SmoothW'({s, 1'b0}) + SmoothW'(s)
                    + SmoothW'({m, 3'b000}) + SmoothW'({m, 1'b0});
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sgr_ram.sv =====
`default_nettype none

module sgr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sgr_window.sv =====
`default_nettype none

module sgr_window
    import sgr_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           clear,
    input  wire logic           adv,
    input  wire sgr_ctl_t       ctl,
    input  wire pix_t           pixel,
    input  wire logic [2*PixW-1:0] mem_rdata,
    output grad_t               grad_x,
    output grad_t               grad_y,
    output logic [2*PixW-1:0]   wb_data
);

    pix_t window_reg [6];
    pix_t window_next [6];
    pix_t nt, nm, nb;
    logic [SmoothW-1:0] sx_new, sx_old, sy_new, sy_old;

    assign nb = pixel;
    assign nm = ctl.row_ge1 ? mem_rdata[2*PixW-1:PixW] : '0;
    assign nt = ctl.row_ge2 ? mem_rdata[PixW-1:0] : '0;

    // {line_prev, line_prev2}; prev2 keeps its old value on the first row
    assign wb_data = {nb, ctl.row_ge1 ? mem_rdata[2*PixW-1:PixW] : mem_rdata[PixW-1:0]};

    assign sx_new = smooth3(nt, nm, nb);
    assign sx_old = smooth3(window_reg[0], window_reg[1], window_reg[2]);
    assign sy_new = smooth3(window_reg[2], window_reg[5], nb);
    assign sy_old = smooth3(window_reg[0], window_reg[3], nt);

    assign grad_x = GradW'(signed'({1'b0, sx_new}) - signed'({1'b0, sx_old}));
    assign grad_y = GradW'(signed'({1'b0, sy_new}) - signed'({1'b0, sy_old}));

    always_comb
    begin
        window_next[0] = window_reg[3];
        window_next[1] = window_reg[4];
        window_next[2] = window_reg[5];
        window_next[3] = nt;
        window_next[4] = nm;
        window_next[5] = nb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scharr_gradient_3x3_core.sv =====
// Streaming 3x3 Scharr gradient of an 8-bit grayscale image.
// Input channel (in_valid/in_ready, pixel) takes one pixel per beat in raster
// order. Output channel (out_valid/out_ready) gives grad_x, grad_y, the centre
// coordinates out_col/out_row and frame_done on the last interior result.
// Border rows and columns produce no output beat.
// Throughput: one pixel per cycle while the output is not stalled; the shared
// line-store RAM does one read at acceptance and one write-back when the pixel
// leaves the compute stage, at different columns, so no forwarding or interlock
// is needed. Each pixel's RAM read is registered beside it in the compute stage;
// its result is then computed into the output register.
// A stalled receiver holds the output register; one more pixel can still be
// taken into the compute stage before in_ready drops.
// Reset: image_width=640, image_height=480, counters and window cleared. The
// line store is not cleared; its reads are masked to zero until written.
// APB writes to either register restart the frame; write only when idle.
`default_nettype none

module scharr_gradient_3x3_core
    import sgr_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [PixW-1:0]    pixel,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [GradW-1:0] grad_x,
    output logic signed [GradW-1:0] grad_y,
    output logic [OutColW-1:0]      out_col,
    output logic [RowW-1:0]         out_row,
    output logic                    frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CfgW-1:0] image_width_reg, image_height_reg;
    logic            cfg_wr, cfg_idx;
    logic [CW-1:0]   last_col;
    logic [RowW-1:0] last_row;

    logic [CW-1:0]   col_reg, col_next;
    logic [RowW-1:0] row_reg, row_next;

    logic            accept, s1_adv, out_load;
    logic            s1_valid_reg, out_valid_reg;
    pix_t            s1_pixel_reg;
    logic [CW-1:0]   s1_col_reg;
    sgr_ctl_t        s1_ctl_reg, ctl_new;
    logic [OutColW-1:0] s1_out_col_reg;
    logic [RowW-1:0] s1_out_row_reg;
    logic [2*PixW-1:0] mem_rdata, wb_data;
    grad_t           gx, gy;

    grad_t           grad_x_reg, grad_y_reg;
    logic [OutColW-1:0] out_col_reg;
    logic [RowW-1:0] out_row_reg;
    logic            frame_done_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (cfg_idx == REG_IMAGE_WIDTH) ? {20'd0, image_width_reg}
                                                 : {20'd0, image_height_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CfgW-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CfgW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg < CfgW'(3))
            last_col = CW'(2);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            last_col = CW'(MAX_WIDTH - 1);
        else
            last_col = CW'(image_width_reg - CfgW'(1));
        if (image_height_reg < CfgW'(3))
            last_row = RowW'(2);
        else
            last_row = image_height_reg - RowW'(1);
    end

    // handshake
    assign s1_adv   = s1_valid_reg && (!s1_ctl_reg.has_result || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;
    assign out_load = s1_adv && s1_ctl_reg.has_result;

    // raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + RowW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        ctl_new.row_ge1    = (row_reg >= RowW'(1));
        ctl_new.row_ge2    = (row_reg >= RowW'(2));
        ctl_new.has_result = (row_reg >= RowW'(2)) && (col_reg >= CW'(2));
        ctl_new.last       = (row_reg == last_row) && (col_reg == last_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg   <= pixel;
            s1_col_reg     <= col_reg;
            s1_ctl_reg     <= ctl_new;
            s1_out_col_reg <= OutColW'(col_reg - CW'(1));
            s1_out_row_reg <= row_reg - RowW'(1);
        end
        if (out_load)
        begin
            grad_x_reg     <= gx;
            grad_y_reg     <= gy;
            out_col_reg    <= s1_out_col_reg;
            out_row_reg    <= s1_out_row_reg;
            frame_done_reg <= s1_ctl_reg.last;
        end
    end

    // {line_prev, line_prev2} per column
    sgr_ram #(
        .WIDTH (2*PixW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (wb_data),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mem_rdata)
    );

    sgr_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_wr),
        .adv       (s1_adv),
        .ctl       (s1_ctl_reg),
        .pixel     (s1_pixel_reg),
        .mem_rdata (mem_rdata),
        .grad_x    (gx),
        .grad_y    (gy),
        .wb_data   (wb_data)
    );

    assign out_valid  = out_valid_reg;
    assign grad_x     = grad_x_reg;
    assign grad_y     = grad_y_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign frame_done = frame_done_reg;

endmodule

`default_nettype wire
